FILE: design/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers used by sparse_matrix_triple_store.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication check failed");

`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`else

`define ASSERT_IMPLY(label, clk, rst_n, ante, cons)

`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

FILE: design/smts_pkg.sv
// ----------------------------------------------------------------------------
// smts_pkg
// Types, codes and microcode ROM of the sparse matrix triple store.
// ----------------------------------------------------------------------------
package smts_pkg;

  localparam int REG_W     = 16;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COLUMN_COUNT = 2'd1;

  localparam logic CMD_READ   = 1'b0;
  localparam logic CMD_MODIFY = 1'b1;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_SCAN_RD,
    S_SCAN_CMP,
    S_HIT,
    S_MODIFY,
    S_DEL_RD,
    S_DEL_WR,
    S_ABSENT,
    S_RESP
  } step_t;

  typedef enum logic [3:0] {
    ACT_ACCEPT,
    ACT_CHECK,
    ACT_READ_PTR,
    ACT_SCAN_NEXT,
    ACT_TAKE,
    ACT_OVERWRITE,
    ACT_SHIFT_RD,
    ACT_SHIFT_WR,
    ACT_APPEND,
    ACT_RESPOND
  } act_t;

  typedef enum logic [3:0] {
    C_ALWAYS,
    C_IN_VALID,
    C_RANGE_ERR,
    C_PTR_AT_COUNT,
    C_MATCH,
    C_CMD_READ,
    C_NV_ZERO,
    C_LAST,
    C_OUT_FREE
  } cond_sel_t;

  typedef struct packed {
    logic in_valid;
    logic range_err;
    logic ptr_at_count;
    logic match;
    logic cmd_read;
    logic nv_zero;
    logic last;
    logic out_free;
  } cond_t;

  typedef struct packed {
    act_t      act;
    cond_sel_t cond;
    step_t     jmp_t;
    step_t     jmp_f;
  } ctrl_word_t;

  function automatic ctrl_word_t ucode(input step_t s);
    ctrl_word_t w;
    w = '{act: ACT_ACCEPT, cond: C_IN_VALID, jmp_t: S_CHECK, jmp_f: S_IDLE};
    unique case (s)
      S_IDLE:     w = '{ACT_ACCEPT,    C_IN_VALID,     S_CHECK,    S_IDLE};
      S_CHECK:    w = '{ACT_CHECK,     C_RANGE_ERR,    S_RESP,     S_SCAN_RD};
      S_SCAN_RD:  w = '{ACT_READ_PTR,  C_PTR_AT_COUNT, S_ABSENT,   S_SCAN_CMP};
      S_SCAN_CMP: w = '{ACT_SCAN_NEXT, C_MATCH,        S_HIT,      S_SCAN_RD};
      S_HIT:      w = '{ACT_TAKE,      C_CMD_READ,     S_RESP,     S_MODIFY};
      S_MODIFY:   w = '{ACT_OVERWRITE, C_NV_ZERO,      S_DEL_RD,   S_RESP};
      S_DEL_RD:   w = '{ACT_SHIFT_RD,  C_LAST,         S_RESP,     S_DEL_WR};
      S_DEL_WR:   w = '{ACT_SHIFT_WR,  C_ALWAYS,       S_DEL_RD,   S_DEL_RD};
      S_ABSENT:   w = '{ACT_APPEND,    C_ALWAYS,       S_RESP,     S_RESP};
      S_RESP:     w = '{ACT_RESPOND,   C_OUT_FREE,     S_IDLE,     S_RESP};
      default:    w = '{ACT_ACCEPT,    C_IN_VALID,     S_CHECK,    S_IDLE};
    endcase
    return w;
  endfunction

endpackage

FILE: design/smts_seq.sv
// ----------------------------------------------------------------------------
// smts_seq
// Microcode sequencer: step counter, control ROM and conditional jumps.
// ----------------------------------------------------------------------------
module smts_seq
  import smts_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  cond_t      flags,
  output ctrl_word_t ctrl
);

  step_t step_r;
  step_t step_nxt;
  logic  taken;

  always_comb begin
    unique case (ctrl.cond)
      C_ALWAYS:       taken = 1'b1;
      C_IN_VALID:     taken = flags.in_valid;
      C_RANGE_ERR:    taken = flags.range_err;
      C_PTR_AT_COUNT: taken = flags.ptr_at_count;
      C_MATCH:        taken = flags.match;
      C_CMD_READ:     taken = flags.cmd_read;
      C_NV_ZERO:      taken = flags.nv_zero;
      C_LAST:         taken = flags.last;
      C_OUT_FREE:     taken = flags.out_free;
      default:        taken = 1'b1;
    endcase
    step_nxt = taken ? ctrl.jmp_t : ctrl.jmp_f;
  end

  always_comb begin
    ctrl = ucode(step_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= S_IDLE;
    end else begin
      step_r <= step_nxt;
    end
  end

endmodule

FILE: design/sparse_matrix_triple_store.sv
// ----------------------------------------------------------------------------
// sparse_matrix_triple_store
// Coordinate-list sparse matrix store with read and modify requests.
// ----------------------------------------------------------------------------
// Holds up to MAX_ENTRIES nonzero (row, column, value) triples in one
// single-port memory, in insertion order, and handles one request at a time.
// A request with out-of-range indices responds at once. Otherwise each stored
// triple is read and compared in turn until a hit or the end of the list. A
// hit returns the stored value; a modify hit overwrites it, or for a zero
// value deletes it by shifting each later triple down; a miss appends a
// nonzero modify value unless the store is full. The memory port does one
// read or one write a cycle. The result sits in an output register, so the
// next request is taken while it waits. The user writes configuration
// registers only while no request is in flight; the block does not enforce
// it. No clearing pass runs after reset.
`include "assert_macros.svh"

module sparse_matrix_triple_store
  import smts_pkg::*;
#(
  parameter int MAX_ENTRIES = 256,
  parameter int INDEX_BITS  = 16,
  parameter int VALUE_BITS  = 32
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [CFG_IDX_W-1:0]         cfg_index,
  input  logic [REG_W-1:0]             cfg_wdata,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         in_command,
  input  logic [INDEX_BITS-1:0]        in_row_index,
  input  logic [INDEX_BITS-1:0]        in_column_index,
  input  logic signed [VALUE_BITS-1:0] in_new_value,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [VALUE_BITS-1:0] out_value_out,
  output logic [1:0]                   out_status
);

  localparam int CNT_W   = $clog2(MAX_ENTRIES + 1);
  localparam int ADDR_W  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int ENTRY_W = 2 * INDEX_BITS + VALUE_BITS;
  localparam int CMP_W   = (INDEX_BITS > REG_W) ? INDEX_BITS : REG_W;

  ctrl_word_t ctrl;
  cond_t      flags;

  logic [REG_W-1:0] row_count_r;
  logic [REG_W-1:0] column_count_r;

  logic                  cmd_r;
  logic [INDEX_BITS-1:0] row_r;
  logic [INDEX_BITS-1:0] col_r;
  logic [VALUE_BITS-1:0] nv_r;

  logic [CNT_W-1:0] ptr_r, ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] ptr_plus1;

  logic [VALUE_BITS-1:0] result_r, result_nxt;
  status_t               status_r, status_nxt;

  logic [ENTRY_W-1:0] mem [MAX_ENTRIES];
  logic [ENTRY_W-1:0] rd_data_r;
  logic               rd_en;
  logic [ADDR_W-1:0]  rd_addr;
  logic               wr_en;
  logic [ADDR_W-1:0]  wr_addr;
  logic [ENTRY_W-1:0] wr_data;
  logic [ENTRY_W-1:0] new_entry;

  logic [VALUE_BITS-1:0] rd_value;
  logic [INDEX_BITS-1:0] rd_col;
  logic [INDEX_BITS-1:0] rd_row;
  logic                  store_full;
  logic                  in_accept;

  logic                  out_load;
  logic                  out_valid_r, out_valid_nxt;
  logic [VALUE_BITS-1:0] out_value_r;
  status_t               out_status_r;

  smts_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .flags (flags),
    .ctrl  (ctrl)
  );

  assign in_stall  = (ctrl.act != ACT_ACCEPT);
  assign in_accept = in_valid && !in_stall;

  assign rd_value   = rd_data_r[VALUE_BITS-1:0];
  assign rd_col     = rd_data_r[VALUE_BITS +: INDEX_BITS];
  assign rd_row     = rd_data_r[VALUE_BITS + INDEX_BITS +: INDEX_BITS];
  assign new_entry  = {row_r, col_r, nv_r};
  assign ptr_plus1  = ptr_r + CNT_W'(1);
  assign store_full = (count_r == CNT_W'(MAX_ENTRIES));

  always_comb begin
    flags.in_valid     = in_valid;
    flags.range_err    = (CMP_W'(row_r) >= CMP_W'(row_count_r)) ||
                         (CMP_W'(col_r) >= CMP_W'(column_count_r));
    flags.ptr_at_count = (ptr_r == count_r);
    flags.match        = (rd_row == row_r) && (rd_col == col_r);
    flags.cmd_read     = (cmd_r == CMD_READ);
    flags.nv_zero      = (nv_r == '0);
    flags.last         = (ptr_plus1 >= count_r);
    flags.out_free     = !out_valid_r || !out_stall;
  end

  always_comb begin
    ptr_nxt    = ptr_r;
    count_nxt  = count_r;
    result_nxt = result_r;
    status_nxt = status_r;
    rd_en      = 1'b0;
    rd_addr    = ptr_r[ADDR_W-1:0];
    wr_en      = 1'b0;
    wr_addr    = ptr_r[ADDR_W-1:0];
    wr_data    = new_entry;
    out_load   = 1'b0;
    unique case (ctrl.act)
      ACT_ACCEPT: begin
      end
      ACT_CHECK: begin
        ptr_nxt    = '0;
        result_nxt = '0;
        status_nxt = flags.range_err ? ST_RANGE : ST_OK;
      end
      ACT_READ_PTR: begin
        rd_en = !flags.ptr_at_count;
      end
      ACT_SCAN_NEXT: begin
        if (!flags.match) begin
          ptr_nxt = ptr_plus1;
        end
      end
      ACT_TAKE: begin
        result_nxt = rd_value;
      end
      ACT_OVERWRITE: begin
        wr_en = (cmd_r == CMD_MODIFY) && !flags.nv_zero;
      end
      ACT_SHIFT_RD: begin
        if (flags.last) begin
          count_nxt = count_r - CNT_W'(1);
        end else begin
          rd_en   = 1'b1;
          rd_addr = ptr_plus1[ADDR_W-1:0];
        end
      end
      ACT_SHIFT_WR: begin
        wr_en   = 1'b1;
        wr_data = rd_data_r;
        ptr_nxt = ptr_plus1;
      end
      ACT_APPEND: begin
        if ((cmd_r == CMD_MODIFY) && !flags.nv_zero) begin
          if (store_full) begin
            status_nxt = ST_FULL;
          end else begin
            wr_en     = 1'b1;
            wr_addr   = count_r[ADDR_W-1:0];
            count_nxt = count_r + CNT_W'(1);
          end
        end
      end
      ACT_RESPOND: begin
        out_load = flags.out_free;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_count_r    <= '0;
      column_count_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ROW_COUNT:    row_count_r    <= cfg_wdata;
        CFG_COLUMN_COUNT: column_count_r <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      cmd_r <= in_command;
      row_r <= in_row_index;
      col_r <= in_column_index;
      nv_r  <= in_new_value;
    end
    ptr_r    <= ptr_nxt;
    result_r <= result_nxt;
    status_r <= status_nxt;
    if (out_load) begin
      out_value_r  <= result_r;
      out_status_r <= status_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_value_out = out_value_r;
  assign out_status    = out_status_r;

  `ASSERT_IMPLY(a_count_bound, clk, rst_n, 1'b1, count_r <= CNT_W'(MAX_ENTRIES))
  `ASSERT_IMPLY(a_scan_in_list, clk, rst_n, ctrl.act == ACT_SCAN_NEXT, ptr_r < count_r)
  `ASSERT_IMPLY(a_full_status, clk, rst_n, ctrl.act == ACT_RESPOND && status_r == ST_FULL, store_full)
  `ASSERT_NEXT(a_delete_shrinks, clk, rst_n, ctrl.act == ACT_SHIFT_RD && flags.last, count_r == CNT_W'($past(count_r) - CNT_W'(1)))

endmodule

FILE: verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the sparse matrix triple store. A behavioral copy
// of the coordinate list predicts the value and status of every request;
// directed cases cover reset, hits, overwrites, deletes, bounds and a full
// store, and random phases sweep several matrix shapes, most of them under
// random backpressure on both channels.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import smts_pkg::*;

  localparam int STORE_DEPTH = 256;
  localparam int INDEX_W     = 16;
  localparam int VALUE_W     = 32;
  localparam int CYCLE_LIMIT = 6_000_000;

  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_B = 2'd3;

  typedef struct {
    logic signed [VALUE_W-1:0] value;
    status_t                   status;
  } result_t;

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]       cfg_index = '0;
  logic [REG_W-1:0]           cfg_wdata = '0;
  logic                       in_valid = 1'b0;
  logic                       in_stall;
  logic                       in_command = CMD_READ;
  logic [INDEX_W-1:0]         in_row_index = '0;
  logic [INDEX_W-1:0]         in_column_index = '0;
  logic signed [VALUE_W-1:0]  in_new_value = '0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic signed [VALUE_W-1:0]  out_value_out;
  logic [1:0]                 out_status;

  // predictor copy of the store
  int                         row_limit;
  int                         col_limit;
  logic [INDEX_W-1:0]         store_row [STORE_DEPTH];
  logic [INDEX_W-1:0]         store_col [STORE_DEPTH];
  logic signed [VALUE_W-1:0]  store_val [STORE_DEPTH];
  int                         store_count;

  result_t                    pending_results [$];

  bit                         idle_off;
  int                         stall_left;
  int                         cycle_count;
  int                         error_count;
  int                         results_seen;
  int                         n_read, n_modify, n_append, n_overwrite, n_delete;
  int                         n_range, n_full, n_settings;

  sparse_matrix_triple_store #(
    .MAX_ENTRIES(STORE_DEPTH),
    .INDEX_BITS (INDEX_W),
    .VALUE_BITS (VALUE_W)
  ) dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_command     (in_command),
    .in_row_index   (in_row_index),
    .in_column_index(in_column_index),
    .in_new_value   (in_new_value),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_value_out  (out_value_out),
    .out_status     (out_status)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding", cycle_count,
               pending_results.size());
      $display("FAIL");
      $finish;
    end
  end

  always @(negedge clk) begin
    if (idle_off) begin
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 5) == 0) begin
      out_stall  <= 1'b1;
      stall_left <= $urandom_range(0, 3);
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic flag_error(input string msg);
    if (error_count < 10) $display("ERROR cycle %0d: %s", cycle_count, msg);
    error_count++;
  endtask

  always @(posedge clk) begin : check_results
    result_t want;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        flag_error($sformatf("unexpected result value=%0d status=%0d",
                             out_value_out, out_status));
      end else begin
        want = pending_results.pop_front();
        if (out_value_out !== want.value || out_status !== want.status) begin
          flag_error($sformatf("value exp %0d got %0d, status exp %0d got %0d",
                               want.value, out_value_out, want.status, out_status));
        end
      end
    end
  end

  function automatic int locate_entry(input logic [INDEX_W-1:0] r,
                                      input logic [INDEX_W-1:0] c);
    for (int k = 0; k < store_count; k++) begin
      if (store_row[k] == r && store_col[k] == c) return k;
    end
    return store_count;
  endfunction

  function automatic void apply_cfg(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [REG_W-1:0] data);
    case (idx)
      CFG_ROW_COUNT:    row_limit = int'(data);
      CFG_COLUMN_COUNT: col_limit = int'(data);
      default: ;
    endcase
  endfunction

  task automatic predict_request(input logic cmd, input logic [INDEX_W-1:0] r,
                                 input logic [INDEX_W-1:0] c,
                                 input logic signed [VALUE_W-1:0] nv);
    result_t res;
    int      slot;
    res.value  = '0;
    res.status = ST_OK;
    if (r >= row_limit || c >= col_limit) begin
      res.status = ST_RANGE;
      n_range++;
    end else begin
      slot = locate_entry(r, c);
      if (slot < store_count) begin
        res.value = store_val[slot];
        if (cmd == CMD_MODIFY) begin
          if (nv == 0) begin
            for (int k = slot; k + 1 < store_count; k++) begin
              store_row[k] = store_row[k + 1];
              store_col[k] = store_col[k + 1];
              store_val[k] = store_val[k + 1];
            end
            store_count--;
            n_delete++;
          end else begin
            store_val[slot] = nv;
            n_overwrite++;
          end
        end
      end else if (cmd == CMD_MODIFY && nv != 0) begin
        if (store_count >= STORE_DEPTH) begin
          res.status = ST_FULL;
          n_full++;
        end else begin
          store_row[store_count] = r;
          store_col[store_count] = c;
          store_val[store_count] = nv;
          store_count++;
          n_append++;
        end
      end
    end
    pending_results.push_back(res);
  endtask

  task automatic send_request(input logic cmd, input logic [INDEX_W-1:0] r,
                              input logic [INDEX_W-1:0] c,
                              input logic signed [VALUE_W-1:0] nv);
    if (!idle_off && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_valid        <= 1'b1;
    in_command      <= cmd;
    in_row_index    <= r;
    in_column_index <= c;
    in_new_value    <= nv;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_request(cmd, r, c, nv);
    if (cmd == CMD_READ) n_read++;
    else n_modify++;
    @(negedge clk);
  endtask

  // drop valid and wait until every result is back
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_dims(input int rows, input int cols);
    logic [CFG_IDX_W-1:0] spare;
    logic [REG_W-1:0]     junk;
    spare = ($urandom_range(0, 1) == 0) ? CFG_UNUSED_A : CFG_UNUSED_B;
    junk  = REG_W'($urandom);
    settle();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_ROW_COUNT;
    cfg_wdata <= REG_W'(rows);
    apply_cfg(CFG_ROW_COUNT, REG_W'(rows));
    @(negedge clk);
    cfg_index <= CFG_COLUMN_COUNT;
    cfg_wdata <= REG_W'(cols);
    apply_cfg(CFG_COLUMN_COUNT, REG_W'(cols));
    @(negedge clk);
    cfg_index <= spare;
    cfg_wdata <= junk;
    apply_cfg(spare, junk);
    @(negedge clk);
    cfg_we <= 1'b0;
    n_settings++;
  endtask

  function automatic logic signed [VALUE_W-1:0] pick_value();
    int s;
    s = $urandom_range(0, 99);
    if (s < 30) return '0;
    if (s < 34) return 32'sh7FFF_FFFF;
    if (s < 38) return 32'sh8000_0000;
    if (s < 41) return -32'sd1;
    if (s < 43) return 32'sd1;
    return $urandom;
  endfunction

  task automatic random_requests(input int count);
    int                 sel;
    int                 k;
    logic               cmd;
    logic [INDEX_W-1:0] r;
    logic [INDEX_W-1:0] c;
    for (int i = 0; i < count; i++) begin
      sel = $urandom_range(0, 99);
      r   = INDEX_W'($urandom);
      c   = INDEX_W'($urandom);
      if (sel < 40 && store_count > 0) begin
        k = $urandom_range(0, store_count - 1);
        r = store_row[k];
        c = store_col[k];
      end else if (sel < 75 && row_limit > 0 && col_limit > 0) begin
        r = INDEX_W'($urandom_range(0, row_limit - 1));
        c = INDEX_W'($urandom_range(0, col_limit - 1));
      end else if (sel < 88) begin
        if ($urandom_range(0, 1) == 0) begin
          r = INDEX_W'(row_limit);
          if (col_limit > 0) c = INDEX_W'($urandom_range(0, col_limit - 1));
        end else begin
          c = INDEX_W'(col_limit);
          if (row_limit > 0) r = INDEX_W'($urandom_range(0, row_limit - 1));
        end
      end
      cmd = ($urandom_range(0, 99) < 35) ? CMD_READ : CMD_MODIFY;
      send_request(cmd, r, c, pick_value());
    end
  endtask

  task automatic test_reset_state();
    send_request(CMD_READ, 16'd0, 16'd0, 32'sd0);
    send_request(CMD_MODIFY, 16'd0, 16'd0, 32'sd1);
    send_request(CMD_MODIFY, 16'hFFFF, 16'hFFFF, -32'sd1);
  endtask

  task automatic test_basic_ops();
    write_dims(4, 4);
    send_request(CMD_READ, 16'd0, 16'd0, 32'sd0);
    send_request(CMD_MODIFY, 16'd0, 16'd0, 32'sd5);
    send_request(CMD_MODIFY, 16'd1, 16'd2, 32'sh7FFF_FFFF);
    send_request(CMD_MODIFY, 16'd3, 16'd3, 32'sh8000_0000);
    send_request(CMD_MODIFY, 16'd2, 16'd1, -32'sd1);
    send_request(CMD_READ, 16'd1, 16'd2, 32'sd0);
    send_request(CMD_MODIFY, 16'd0, 16'd0, 32'sd7);
    send_request(CMD_MODIFY, 16'd1, 16'd2, 32'sd0);
    send_request(CMD_READ, 16'd3, 16'd3, 32'sd0);
    send_request(CMD_MODIFY, 16'd2, 16'd2, 32'sd0);
    send_request(CMD_READ, 16'd4, 16'd0, 32'sd0);
    send_request(CMD_READ, 16'd0, 16'd4, 32'sd0);
    send_request(CMD_MODIFY, 16'hFFFF, 16'hFFFF, 32'sd9);
    send_request(CMD_MODIFY, 16'd0, 16'd0, 32'sd0);
    send_request(CMD_MODIFY, 16'd2, 16'd1, 32'sd0);
    send_request(CMD_READ, 16'd3, 16'd3, 32'sd0);
    send_request(CMD_READ, 16'd2, 16'd1, 32'sd0);
  endtask

  task automatic test_dimension_edges();
    write_dims(65535, 65535);
    send_request(CMD_MODIFY, 16'hFFFE, 16'hFFFE, 32'sd1);
    send_request(CMD_READ, 16'hFFFF, 16'd0, 32'sd0);
    send_request(CMD_READ, 16'd0, 16'hFFFF, 32'sd0);
    send_request(CMD_MODIFY, 16'hFFFE, 16'hFFFE, 32'sd0);
    write_dims(1, 1);
    send_request(CMD_MODIFY, 16'd0, 16'd0, 32'sd9);
    send_request(CMD_READ, 16'd0, 16'd1, 32'sd0);
    send_request(CMD_READ, 16'd1, 16'd0, 32'sd0);
    send_request(CMD_MODIFY, 16'd0, 16'd0, 32'sd0);
  endtask

  task automatic test_random_mix();
    write_dims(8, 8);
    random_requests(150);
    write_dims(65535, 65535);
    random_requests(150);
    write_dims(3, 300);
    random_requests(100);
    write_dims(1, 1);
    random_requests(50);
    write_dims(0, 40);
    random_requests(30);
    write_dims(65535, 1);
    random_requests(80);
    write_dims(300, 65535);
    random_requests(100);
  endtask

  task automatic test_store_full();
    logic [INDEX_W-1:0] r;
    logic [INDEX_W-1:0] c;
    write_dims(65535, 65535);
    while (store_count < STORE_DEPTH + 4) begin
      r = INDEX_W'($urandom_range(0, 65534));
      c = INDEX_W'($urandom_range(0, 65534));
      if (locate_entry(r, c) == store_count) begin
        send_request(CMD_MODIFY, r, c, $urandom | 32'sd1);
        if (n_full > 0 && store_count == STORE_DEPTH) break;
      end
    end
    send_request(CMD_MODIFY, store_row[10], store_col[10], pick_value() | 32'sd2);
    send_request(CMD_READ, store_row[10], store_col[10], 32'sd0);
    send_request(CMD_MODIFY, store_row[0], store_col[0], 32'sd0);
    send_request(CMD_MODIFY, 16'hFFFE, 16'd0, 32'sh8000_0000);
    send_request(CMD_MODIFY, 16'd1, 16'hFFFE, 32'sd3);
    send_request(CMD_MODIFY, store_row[STORE_DEPTH - 1], store_col[STORE_DEPTH - 1], 32'sd0);
    send_request(CMD_MODIFY, 16'd7, 16'hFFFE, 32'sh7FFF_FFFF);
    send_request(CMD_READ, store_row[STORE_DEPTH - 1], store_col[STORE_DEPTH - 1], 32'sd0);
    random_requests(40);
  endtask

  task automatic test_steady_stream();
    idle_off = 1'b1;
    write_dims(16, 17);
    random_requests(150);
  endtask

  initial begin
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_reset_state();
    test_basic_ops();
    test_dimension_edges();
    test_random_mix();
    test_store_full();
    test_steady_stream();
    settle();
    repeat (20) @(posedge clk);
    if (pending_results.size() != 0) begin
      flag_error($sformatf("%0d results never arrived", pending_results.size()));
    end
    $display("Covered %0d requests (%0d reads, %0d modifies) over %0d shapes, %0d checked",
             n_read + n_modify, n_read, n_modify, n_settings, results_seen);
    $display("  appends %0d, overwrites %0d, deletes %0d, out of range %0d, store full %0d",
             n_append, n_overwrite, n_delete, n_range, n_full);
    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("%0d mismatches", error_count);
      $display("FAIL");
    end
    $finish;
  end

endmodule

FILE: sparse_matrix_triple_store.f
+incdir+design
design/smts_pkg.sv
design/smts_seq.sv
design/sparse_matrix_triple_store.sv
verif/tb_top.sv
